[design/bscm_pkg.sv]
// Package for the byte store copy/move engine: command codes, status codes and control structs.
package bscm_pkg;

    // Command codes carried on the command port.
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_COPY  = 3'd3;
    localparam logic [2:0] CMD_MOVE  = 3'd4;

    // Status codes returned with every result word.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;

    // Value of an erased byte.
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // latch the command word
        logic clr_step;     // erase one entry of the clearing pass
        logic wr_single;    // write the data byte at the target address
        logic rd_issue;     // read the byte at the target address
        logic walk_init;    // set up pointers and count for fill, copy or move
        logic fill_write;   // write one fill byte and step
        logic cp_read;      // read one source byte
        logic cp_write;     // write the fetched byte to the destination and step
        logic erase_init;   // set up pointer and count for the move erase
        logic erase_write;  // erase one uncovered source byte and step
        logic finish;       // capture the result word
        logic finish_read;  // the result carries the byte just read
    } bscm_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       addr_err;
        logic       size_err;
        logic       empty;
        logic       walk_last;
        logic       clr_last;
    } bscm_sts_t;

endpackage

[design/byte_store_copy_move_engine_top.sv]
// Top level of the byte store copy/move engine: controller, datapath and checks.
//
// A command word is taken when start is high and busy is low; one result word (status
// and read_data) follows on a one-cycle done strobe that cannot be held off. After reset
// the block clears its store to 0xFF, one entry a cycle, and stays busy until the
// clearing pass has reached the last entry. Fill writes the data byte over the range,
// copy reads each source byte in S_CP_RD and writes it in S_CP_WR, and move copies and
// then erases the source bytes that the destination does not cover. The byte memory
// has one write port and one registered read port.
module byte_store_copy_move_engine_top
    import bscm_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] address,
    input  logic [15:0] source_address,
    input  logic [15:0] length,
    input  logic [7:0]  data,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  read_data
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    bscm_ctl_t ctl;
    bscm_sts_t sts;

    // Sequencer.
    bscm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Memory, checks and result word.
    bscm_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .command        (command),
        .address        (address),
        .source_address (source_address),
        .length         (length),
        .data           (data),
        .done           (done),
        .status         (status),
        .read_data      (read_data)
    );

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // The result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // No result appears in the cycle right after an accept.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(start && !busy))
        else $error("result came too early");

    // A failed command returns no read byte.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (read_data == 8'd0))
        else $error("read byte returned with an error status");

endmodule

[design/bscm_ctrl.sv]
// Controller state machine of the byte store copy/move engine.
module bscm_ctrl
    import bscm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bscm_sts_t sts,
    output bscm_ctl_t ctl,
    output logic      busy
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_RD_WAIT = 4'd3;
    localparam logic [3:0] S_FILL    = 4'd4;
    localparam logic [3:0] S_CP_RD   = 4'd5;
    localparam logic [3:0] S_CP_WR   = 4'd6;
    localparam logic [3:0] S_ER_INIT = 4'd7;
    localparam logic [3:0] S_ERASE   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (sts.addr_err || sts.size_err)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.cmd == CMD_READ)
                begin
                    ctl.rd_issue = 1'b1;
                    state_next   = S_RD_WAIT;
                end
                else if (sts.cmd == CMD_WRITE)
                begin
                    ctl.wr_single = 1'b1;
                    ctl.finish    = 1'b1;
                    state_next    = S_IDLE;
                end
                else if ((sts.cmd == CMD_FILL) && !sts.empty)
                begin
                    ctl.walk_init = 1'b1;
                    state_next    = S_FILL;
                end
                else if (((sts.cmd == CMD_COPY) || (sts.cmd == CMD_MOVE)) && !sts.empty)
                begin
                    ctl.walk_init = 1'b1;
                    state_next    = S_CP_RD;
                end
                else
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_WAIT:
            begin
                ctl.finish      = 1'b1;
                ctl.finish_read = 1'b1;
                state_next      = S_IDLE;
            end
            S_FILL:
            begin
                ctl.fill_write = 1'b1;
                if (sts.walk_last)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CP_RD:
            begin
                ctl.cp_read = 1'b1;
                state_next  = S_CP_WR;
            end
            S_CP_WR:
            begin
                ctl.cp_write = 1'b1;
                priority if (!sts.walk_last)
                begin
                    state_next = S_CP_RD;
                end
                else if (sts.cmd == CMD_MOVE)
                begin
                    state_next = S_ER_INIT;
                end
                else
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ER_INIT:
            begin
                ctl.erase_init = 1'b1;
                state_next     = S_ERASE;
            end
            S_ERASE:
            begin
                ctl.erase_write = 1'b1;
                if (sts.walk_last)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/bscm_dp.sv]
// Datapath of the byte store copy/move engine: byte memory, range checks, walk pointers, result word.
module bscm_dp
    import bscm_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int AW          = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  bscm_ctl_t  ctl,
    output bscm_sts_t  sts,
    input  logic [2:0] command,
    input  logic [15:0] address,
    input  logic [15:0] source_address,
    input  logic [15:0] length,
    input  logic [7:0] data,
    output logic       done,
    output logic [1:0] status,
    output logic [7:0] read_data
);

    localparam logic [16:0]   DEPTH_W = 17'(STORE_DEPTH);
    localparam logic [16:0]   LAST_W  = 17'(STORE_DEPTH - 1);
    localparam logic [AW-1:0] LAST_A  = AW'(STORE_DEPTH - 1);

    // Byte memory.
    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] mem_q_reg;

    // Latched command word.
    logic [2:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [15:0] src_reg;
    logic [15:0] len_reg;
    logic [7:0]  data_reg;

    // Walk state.
    logic [AW-1:0] clr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] wr_ptr_reg;
    logic [15:0]   cnt_reg;

    // Result word.
    logic       done_reg;
    logic [1:0] status_reg;
    logic [7:0] read_data_reg;

    // Range checks on the latched command word.
    logic [16:0] addr_w;
    logic [16:0] src_w;
    logic [16:0] len_w;
    logic [16:0] lead_w;
    logic [16:0] dst_end_w;
    logic [16:0] src_end_w;
    logic [16:0] dst_top_w;
    logic [16:0] src_top_w;
    logic        is_copy;
    logic        addr_bad;
    logic        src_bad;
    logic        addr_err;
    logic        size_err;
    logic        desc;
    logic [1:0]  status_c;

    assign addr_w    = {1'b0, addr_reg};
    assign src_w     = {1'b0, src_reg};
    assign len_w     = {1'b0, len_reg};
    assign is_copy   = (cmd_reg == CMD_COPY) || (cmd_reg == CMD_MOVE);
    assign lead_w    = (is_copy && (src_w > addr_w)) ? src_w : addr_w;
    assign dst_end_w = addr_w + len_w;
    assign src_end_w = src_w + len_w;
    assign dst_top_w = dst_end_w - 17'd1;
    assign src_top_w = src_end_w - 17'd1;
    assign addr_bad  = addr_w > LAST_W;
    assign src_bad   = src_w > LAST_W;
    // Only a copy or move with an overlapping source below the destination walks down.
    assign desc      = is_copy && (src_w < addr_w) && (src_end_w > addr_w);

    always_comb
    begin
        addr_err = 1'b0;
        size_err = 1'b0;
        unique case (cmd_reg)
            CMD_READ, CMD_WRITE:
            begin
                addr_err = addr_bad;
            end
            CMD_FILL, CMD_COPY, CMD_MOVE:
            begin
                addr_err = addr_bad || (is_copy && src_bad);
                size_err = !addr_err && (len_reg != 16'd0)
                           && ((lead_w + len_w) > DEPTH_W);
            end
            default:
            begin
                addr_err = 1'b0;
                size_err = 1'b0;
            end
        endcase
    end

    assign status_c = addr_err ? ST_ADDR : (size_err ? ST_SIZE : ST_OK);

    assign sts.cmd       = cmd_reg;
    assign sts.addr_err  = addr_err;
    assign sts.size_err  = size_err;
    assign sts.empty     = (len_reg == 16'd0) || (is_copy && (addr_reg == src_reg));
    assign sts.walk_last = (cnt_reg == 16'd1);
    assign sts.clr_last  = (clr_ptr_reg == LAST_A);

    // Command word capture.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
            src_reg  <= source_address;
            len_reg  <= length;
            data_reg <= data;
        end
    end

    // Clearing pass pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
        end
        else if (ctl.clr_step)
        begin
            clr_ptr_reg <= clr_ptr_reg + AW'(1);
        end
    end

    // Walk pointers and byte count.
    always_ff @(posedge clk)
    begin
        priority if (ctl.walk_init)
        begin
            cnt_reg <= len_reg;
            if (desc)
            begin
                rd_ptr_reg <= src_top_w[AW-1:0];
                wr_ptr_reg <= dst_top_w[AW-1:0];
            end
            else
            begin
                rd_ptr_reg <= src_reg[AW-1:0];
                wr_ptr_reg <= addr_reg[AW-1:0];
            end
        end
        else if (ctl.erase_init)
        begin
            cnt_reg    <= len_reg;
            wr_ptr_reg <= src_reg[AW-1:0];
        end
        else if (ctl.fill_write || ctl.erase_write)
        begin
            cnt_reg    <= cnt_reg - 16'd1;
            wr_ptr_reg <= wr_ptr_reg + AW'(1);
        end
        else if (ctl.cp_write)
        begin
            cnt_reg <= cnt_reg - 16'd1;
            if (desc)
            begin
                rd_ptr_reg <= rd_ptr_reg - AW'(1);
                wr_ptr_reg <= wr_ptr_reg - AW'(1);
            end
            else
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
        end
        else
        begin
            cnt_reg <= cnt_reg;
        end
    end

    // Write port selection; the erase skips bytes that the destination covers.
    logic          wr_en;
    logic [AW-1:0] wr_idx;
    logic [7:0]    wr_byte;
    logic [16:0]   wr_ptr_w;
    logic          uncovered;

    assign wr_ptr_w  = 17'(wr_ptr_reg);
    assign uncovered = (wr_ptr_w < addr_w) || (wr_ptr_w >= dst_end_w);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = wr_ptr_reg;
        wr_byte = data_reg;
        priority if (ctl.clr_step)
        begin
            wr_en   = 1'b1;
            wr_idx  = clr_ptr_reg;
            wr_byte = ERASED_BYTE;
        end
        else if (ctl.wr_single)
        begin
            wr_en  = 1'b1;
            wr_idx = addr_reg[AW-1:0];
        end
        else if (ctl.fill_write)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.cp_write)
        begin
            wr_en   = 1'b1;
            wr_byte = mem_q_reg;
        end
        else if (ctl.erase_write)
        begin
            wr_en   = uncovered;
            wr_byte = ERASED_BYTE;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_byte;
        end
    end

    // Registered read port.
    logic [AW-1:0] rd_idx;

    assign rd_idx = ctl.rd_issue ? addr_reg[AW-1:0] : rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_issue || ctl.cp_read)
        begin
            mem_q_reg <= mem[rd_idx];
        end
    end

    // Result word, shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            status_reg    <= status_c;
            read_data_reg <= ctl.finish_read ? mem_q_reg : 8'd0;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign read_data = read_data_reg;

endmodule
